// ===== rtl/core/lkv_pkg.sv =====
package lkv_pkg;

	// s15.16 elements
	localparam int FRAC_W = 16;
	localparam int ELEM_W = 32;
	// unit components lie in [-1.0, 1.0], so two integer bits are enough
	localparam int UNIT_W = FRAC_W + 2;

	typedef logic signed [UNIT_W-1:0] unit_t;
	typedef logic [ELEM_W-1:0]        elem_t;

	localparam elem_t ELEM_ONE  = 32'h0001_0000;
	localparam elem_t ELEM_ZERO = 32'h0000_0000;

	localparam logic [1:0] LAST_ROW = 2'd3;

endpackage

// ===== rtl/core/lkv_norm.sv =====
module lkv_norm #(
	parameter int W  = 33,
	parameter int PW = 8
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      vec_vld,
	input  logic [2:0][W-1:0]         vec,
	input  logic [PW-1:0]             vec_aux,
	output logic                      res_vld,
	output logic [2:0][lkv_pkg::UNIT_W-1:0] res_unit,
	output logic                      res_zero,
	output logic [PW-1:0]             res_aux
);
	import lkv_pkg::*;

	localparam int NSH = $clog2(W);
	localparam int NSS = (NSH + 1) / 2;
	localparam int AW  = 30;
	localparam int SQW = 2 * AW;
	localparam int SQN = 32;
	localparam int SQS = SQN / 2;
	localparam int DVN = FRAC_W + 1;
	localparam int DVS = (DVN + 1) / 2;
	localparam int LW  = 31;
	localparam int RW  = LW + 1;

	typedef struct packed {
		logic [63:0] rem;
		logic [63:0] res;
	} root_t;

	function automatic root_t root_step(root_t r, int i);
		logic [63:0] b;
		logic [63:0] t;
		root_t       o;
		b = 64'd1 << (62 - 2 * i);
		t = r.res + b;
		o = r;
		if (r.rem >= t) begin
			o.rem = r.rem - t;
			o.res = (r.res >> 1) + b;
		end else begin
			o.res = r.res >> 1;
		end
		return o;
	endfunction

	// magnitude and leading-one alignment
	logic [W-1:0]  mag [3];
	logic [W-1:0]  sh_mag_s  [NSS+1][3];
	logic [2:0]    sh_sgn_s  [NSS+1];
	logic          sh_zero_s [NSS+1];
	logic          sh_vld_s  [NSS+1];
	logic [PW-1:0] sh_aux_s  [NSS+1];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = vec[i][W-1] ? (~vec[i] + 1'b1) : vec[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sh_vld_s[0] <= 1'b0;
		end else if (en) begin
			sh_vld_s[0] <= vec_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sh_mag_s[0][i] <= mag[i];
				sh_sgn_s[0][i] <= vec[i][W-1];
			end
			sh_zero_s[0] <= ~|(mag[0] | mag[1] | mag[2]);
			sh_aux_s[0]  <= vec_aux;
		end
	end

	for (genvar g = 0; g < NSS; g++) begin : g_shift
		logic [W-1:0] nxt [3];

		always_comb begin
			logic [W-1:0] orv;
			int           sh;
			for (int i = 0; i < 3; i++) begin
				nxt[i] = sh_mag_s[g][i];
			end
			for (int k = 0; k < 2; k++) begin
				if (2 * g + k < NSH) begin
					sh  = 1 << (NSH - 1 - 2 * g - k);
					orv = nxt[0] | nxt[1] | nxt[2];
					// shift up while the top bits are clear
					if ((orv >> (W - sh)) == '0) begin
						for (int i = 0; i < 3; i++) begin
							nxt[i] = nxt[i] << sh;
						end
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sh_vld_s[g+1] <= 1'b0;
			end else if (en) begin
				sh_vld_s[g+1] <= sh_vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sh_mag_s[g+1]  <= nxt;
				sh_sgn_s[g+1]  <= sh_sgn_s[g];
				sh_zero_s[g+1] <= sh_zero_s[g];
				sh_aux_s[g+1]  <= sh_aux_s[g];
			end
		end
	end

	// squares of the aligned magnitudes, largest one in [2^29, 2^30)
	logic [AW-1:0]  sq_a_s [3];
	logic [SQW-1:0] sq_p_s [3];
	logic [2:0]     sq_sgn_s;
	logic           sq_zero_s;
	logic           sq_vld_s;
	logic [PW-1:0]  sq_aux_s;
	logic [AW-1:0]  aln [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			aln[i] = sh_mag_s[NSS][i][W-1:W-AW];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s <= 1'b0;
		end else if (en) begin
			sq_vld_s <= sh_vld_s[NSS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_a_s[i] <= aln[i];
				sq_p_s[i] <= SQW'(aln[i]) * SQW'(aln[i]);
			end
			sq_sgn_s  <= sh_sgn_s[NSS];
			sq_zero_s <= sh_zero_s[NSS];
			sq_aux_s  <= sh_aux_s[NSS];
		end
	end

	// square root, two digits a stage
	root_t         rt_s      [SQS+1];
	logic [AW-1:0] rt_a_s    [SQS+1][3];
	logic [2:0]    rt_sgn_s  [SQS+1];
	logic          rt_zero_s [SQS+1];
	logic          rt_vld_s  [SQS+1];
	logic [PW-1:0] rt_aux_s  [SQS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_vld_s[0] <= 1'b0;
		end else if (en) begin
			rt_vld_s[0] <= sq_vld_s;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rt_s[0].rem  <= 64'(sq_p_s[0]) + 64'(sq_p_s[1]) + 64'(sq_p_s[2]);
			rt_s[0].res  <= '0;
			rt_a_s[0]    <= sq_a_s;
			rt_sgn_s[0]  <= sq_sgn_s;
			rt_zero_s[0] <= sq_zero_s;
			rt_aux_s[0]  <= sq_aux_s;
		end
	end

	for (genvar g = 0; g < SQS; g++) begin : g_root
		root_t nxt;

		always_comb begin
			nxt = rt_s[g];
			for (int k = 0; k < 2; k++) begin
				nxt = root_step(nxt, 2 * g + k);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				rt_vld_s[g+1] <= 1'b0;
			end else if (en) begin
				rt_vld_s[g+1] <= rt_vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rt_s[g+1]      <= nxt;
				rt_a_s[g+1]    <= rt_a_s[g];
				rt_sgn_s[g+1]  <= rt_sgn_s[g];
				rt_zero_s[g+1] <= rt_zero_s[g];
				rt_aux_s[g+1]  <= rt_aux_s[g];
			end
		end
	end

	// a * 2^16 / len, restoring, two quotient bits a stage
	logic [LW-1:0]  dv_len_s  [DVS+1];
	logic [RW-1:0]  dv_r_s    [DVS+1][3];
	logic [DVN-1:0] dv_q_s    [DVS+1][3];
	logic [2:0]     dv_a0_s   [DVS+1];
	logic [2:0]     dv_sgn_s  [DVS+1];
	logic           dv_zero_s [DVS+1];
	logic           dv_vld_s  [DVS+1];
	logic [PW-1:0]  dv_aux_s  [DVS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s[0] <= 1'b0;
		end else if (en) begin
			dv_vld_s[0] <= rt_vld_s[SQS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_len_s[0] <= rt_s[SQS].res[LW-1:0];
			for (int i = 0; i < 3; i++) begin
				dv_r_s[0][i]  <= RW'(rt_a_s[SQS][i] >> 1);
				dv_q_s[0][i]  <= '0;
				dv_a0_s[0][i] <= rt_a_s[SQS][i][0];
			end
			dv_sgn_s[0]  <= rt_sgn_s[SQS];
			dv_zero_s[0] <= rt_zero_s[SQS];
			dv_aux_s[0]  <= rt_aux_s[SQS];
		end
	end

	for (genvar g = 0; g < DVS; g++) begin : g_div
		logic [RW-1:0]  rn [3];
		logic [DVN-1:0] qn [3];

		always_comb begin
			logic [RW-1:0] t;
			logic          din;
			t   = '0;
			din = 1'b0;
			for (int i = 0; i < 3; i++) begin
				rn[i] = dv_r_s[g][i];
				qn[i] = dv_q_s[g][i];
				for (int k = 0; k < 2; k++) begin
					if (2 * g + k < DVN) begin
						// only the first step brings in a dividend bit
						din = (2 * g + k == 0) ? dv_a0_s[g][i] : 1'b0;
						t   = {rn[i][RW-2:0], din};
						if (t >= RW'(dv_len_s[g])) begin
							rn[i] = t - RW'(dv_len_s[g]);
							qn[i] = {qn[i][DVN-2:0], 1'b1};
						end else begin
							rn[i] = t;
							qn[i] = {qn[i][DVN-2:0], 1'b0};
						end
					end
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[g+1] <= 1'b0;
			end else if (en) begin
				dv_vld_s[g+1] <= dv_vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_len_s[g+1]  <= dv_len_s[g];
				dv_r_s[g+1]    <= rn;
				dv_q_s[g+1]    <= qn;
				dv_a0_s[g+1]   <= dv_a0_s[g];
				dv_sgn_s[g+1]  <= dv_sgn_s[g];
				dv_zero_s[g+1] <= dv_zero_s[g];
				dv_aux_s[g+1]  <= dv_aux_s[g];
			end
		end
	end

	// apply the sign
	logic                   vld_q;
	logic [2:0][UNIT_W-1:0] unit_q;
	logic                   zero_q;
	logic [PW-1:0]          aux_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= dv_vld_s[DVS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				unit_q[i] <= dv_sgn_s[DVS][i] ? -UNIT_W'(dv_q_s[DVS][i])
				                              : UNIT_W'(dv_q_s[DVS][i]);
			end
			zero_q <= dv_zero_s[DVS];
			aux_q  <= dv_aux_s[DVS];
		end
	end

	assign res_vld  = vld_q;
	assign res_unit = unit_q;
	assign res_zero = zero_q;
	assign res_aux  = aux_q;

endmodule

// ===== rtl/core/look_at_view_matrix_fixed.sv =====
// Channel  Direction  Handshake            Payload
// in       sink       in_valid / in_stall  eye_*, target_*, upward_* (s15.16)
// out      source     out_valid/out_stall  word_row, word_a..word_d, degenerate, last_row
//
// A camera item passes three normalizing units and the cross-product and translation
// stages before its first packed row; the four rows then leave in order, each held
// while out_stall is high. The output register takes the next matrix as the last
// row of the one it holds is sent. The pipeline moves as a whole; it holds while a
// finished matrix waits for the output register, and in_stall is high exactly then.
// arst_n clears the valid bits and the output row counter.
module look_at_view_matrix_fixed (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] eye_x,
	input  logic signed [31:0] eye_y,
	input  logic signed [31:0] eye_z,
	input  logic signed [31:0] target_x,
	input  logic signed [31:0] target_y,
	input  logic signed [31:0] target_z,
	input  logic signed [31:0] upward_x,
	input  logic signed [31:0] upward_y,
	input  logic signed [31:0] upward_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         word_row,
	output logic [31:0]        word_a,
	output logic [31:0]        word_b,
	output logic [31:0]        word_c,
	output logic [31:0]        word_d,
	output logic               degenerate,
	output logic               last_row
);
	import lkv_pkg::*;

	localparam int VW  = 96;
	localparam int LKW = 3 * UNIT_W;
	localparam int A1W = 2 * VW;
	localparam int A2W = VW + LKW + 1;
	localparam int A3W = VW + 2 * LKW + 1;
	localparam int D1W = 33;
	localparam int C1W = 50;
	localparam int C2W = 35;
	localparam int PDW = 50;
	localparam int SDW = 51;
	localparam int TQW = SDW - FRAC_W;
	localparam int NGW = TQW + 1;
	localparam logic signed [NGW-1:0] SAT_HI = NGW'(64'sd2147483647);
	localparam logic signed [NGW-1:0] SAT_LO = NGW'(-64'sd2147483648);

	logic en;

	// first unit: look direction
	logic [2:0][D1W-1:0]    dir;
	logic [A1W-1:0]         aux1;
	logic                   n1_vld;
	logic [2:0][UNIT_W-1:0] n1_unit;
	logic                   n1_zero;
	logic [A1W-1:0]         n1_aux;

	assign dir[0] = {target_x[31], target_x} - {eye_x[31], eye_x};
	assign dir[1] = {target_y[31], target_y} - {eye_y[31], eye_y};
	assign dir[2] = {target_z[31], target_z} - {eye_z[31], eye_z};
	assign aux1   = {upward_z, upward_y, upward_x, eye_z, eye_y, eye_x};

	lkv_norm #(.W(D1W), .PW(A1W)) u_nrm1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vec_vld  (in_valid),
		.vec      (dir),
		.vec_aux  (aux1),
		.res_vld  (n1_vld),
		.res_unit (n1_unit),
		.res_zero (n1_zero),
		.res_aux  (n1_aux)
	);

	// up x look, with look = -unit; the sign folds into the operand order
	logic signed [31:0]    v1 [3];
	unit_t                 u1 [3];
	logic signed [C1W-1:0] p1_s1 [6];
	unit_t                 lk_s1 [3];
	logic [VW-1:0]         eye_s1;
	logic                  deg_s1;
	logic                  vld_s1;
	logic signed [C1W-1:0] cx1_s2 [3];
	unit_t                 lk_s2 [3];
	logic [VW-1:0]         eye_s2;
	logic                  deg_s2;
	logic                  vld_s2;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			v1[i] = $signed(n1_aux[VW + 32 * i +: 32]);
			u1[i] = unit_t'(n1_unit[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= n1_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p1_s1[0] <= v1[2] * u1[1];
			p1_s1[1] <= v1[1] * u1[2];
			p1_s1[2] <= v1[0] * u1[2];
			p1_s1[3] <= v1[2] * u1[0];
			p1_s1[4] <= v1[1] * u1[0];
			p1_s1[5] <= v1[0] * u1[1];
			for (int i = 0; i < 3; i++) begin
				lk_s1[i] <= -u1[i];
			end
			eye_s1 <= n1_aux[VW-1:0];
			deg_s1 <= n1_zero;

			cx1_s2[0] <= p1_s1[0] - p1_s1[1];
			cx1_s2[1] <= p1_s1[2] - p1_s1[3];
			cx1_s2[2] <= p1_s1[4] - p1_s1[5];
			lk_s2     <= lk_s1;
			eye_s2    <= eye_s1;
			deg_s2    <= deg_s1;
		end
	end

	// second unit: right
	logic [2:0][C1W-1:0]    n2_vec;
	logic [A2W-1:0]         aux2;
	logic                   n2_vld;
	logic [2:0][UNIT_W-1:0] n2_unit;
	logic                   n2_zero;
	logic [A2W-1:0]         n2_aux;

	assign n2_vec[0] = cx1_s2[0];
	assign n2_vec[1] = cx1_s2[1];
	assign n2_vec[2] = cx1_s2[2];
	assign aux2      = {deg_s2, lk_s2[2], lk_s2[1], lk_s2[0], eye_s2};

	lkv_norm #(.W(C1W), .PW(A2W)) u_nrm2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vec_vld  (vld_s2),
		.vec      (n2_vec),
		.vec_aux  (aux2),
		.res_vld  (n2_vld),
		.res_unit (n2_unit),
		.res_zero (n2_zero),
		.res_aux  (n2_aux)
	);

	// look x right
	unit_t                 l2 [3];
	unit_t                 r2 [3];
	logic signed [C2W-1:0] p2_s3 [6];
	unit_t                 lk_s3 [3];
	unit_t                 rg_s3 [3];
	logic [VW-1:0]         eye_s3;
	logic                  deg_s3;
	logic                  vld_s3;
	logic signed [C2W-1:0] cx2_s4 [3];
	unit_t                 lk_s4 [3];
	unit_t                 rg_s4 [3];
	logic [VW-1:0]         eye_s4;
	logic                  deg_s4;
	logic                  vld_s4;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			l2[i] = $signed(n2_aux[VW + UNIT_W * i +: UNIT_W]);
			r2[i] = unit_t'(n2_unit[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s3 <= n2_vld;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p2_s3[0] <= l2[1] * r2[2];
			p2_s3[1] <= l2[2] * r2[1];
			p2_s3[2] <= l2[2] * r2[0];
			p2_s3[3] <= l2[0] * r2[2];
			p2_s3[4] <= l2[0] * r2[1];
			p2_s3[5] <= l2[1] * r2[0];
			lk_s3    <= l2;
			rg_s3    <= r2;
			eye_s3   <= n2_aux[VW-1:0];
			deg_s3   <= n2_aux[A2W-1] | n2_zero;

			cx2_s4[0] <= p2_s3[0] - p2_s3[1];
			cx2_s4[1] <= p2_s3[2] - p2_s3[3];
			cx2_s4[2] <= p2_s3[4] - p2_s3[5];
			lk_s4     <= lk_s3;
			rg_s4     <= rg_s3;
			eye_s4    <= eye_s3;
			deg_s4    <= deg_s3;
		end
	end

	// third unit: new up
	logic [2:0][C2W-1:0]    n3_vec;
	logic [A3W-1:0]         aux3;
	logic                   n3_vld;
	logic [2:0][UNIT_W-1:0] n3_unit;
	logic                   n3_zero;
	logic [A3W-1:0]         n3_aux;

	assign n3_vec[0] = cx2_s4[0];
	assign n3_vec[1] = cx2_s4[1];
	assign n3_vec[2] = cx2_s4[2];
	assign aux3      = {deg_s4, rg_s4[2], rg_s4[1], rg_s4[0],
	                    lk_s4[2], lk_s4[1], lk_s4[0], eye_s4};

	lkv_norm #(.W(C2W), .PW(A3W)) u_nrm3 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.vec_vld  (vld_s4),
		.vec      (n3_vec),
		.vec_aux  (aux3),
		.res_vld  (n3_vld),
		.res_unit (n3_unit),
		.res_zero (n3_zero),
		.res_aux  (n3_aux)
	);

	// translation: -(eye . basis), truncated toward zero and saturated
	logic signed [31:0]    e3 [3];
	unit_t                 bs [3][3];
	logic signed [PDW-1:0] pd_s5 [3][3];
	unit_t                 bs_s5 [3][3];
	logic                  deg_s5;
	logic                  vld_s5;
	logic signed [SDW-1:0] sd_s6 [3];
	unit_t                 bs_s6 [3][3];
	logic                  deg_s6;
	logic                  vld_s6;
	elem_t                 tr_s7 [3];
	unit_t                 bs_s7 [3][3];
	logic                  deg_s7;
	logic                  vld_s7;
	elem_t                 trn [3];

	// basis rows: 0 right, 1 new up, 2 look
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			e3[i]    = $signed(n3_aux[32 * i +: 32]);
			bs[2][i] = $signed(n3_aux[VW + UNIT_W * i +: UNIT_W]);
			bs[0][i] = $signed(n3_aux[VW + LKW + UNIT_W * i +: UNIT_W]);
			bs[1][i] = unit_t'(n3_unit[i]);
		end
	end

	always_comb begin
		logic signed [TQW-1:0] tq;
		logic signed [NGW-1:0] ng;
		for (int k = 0; k < 3; k++) begin
			tq = sd_s6[k][SDW-1:FRAC_W];
			if (sd_s6[k][SDW-1] && (|sd_s6[k][FRAC_W-1:0])) begin
				tq = tq + TQW'(1);
			end
			ng = -{tq[TQW-1], tq};
			if (ng > SAT_HI) begin
				trn[k] = SAT_HI[31:0];
			end else if (ng < SAT_LO) begin
				trn[k] = SAT_LO[31:0];
			end else begin
				trn[k] = ng[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s5 <= n3_vld;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				for (int i = 0; i < 3; i++) begin
					pd_s5[k][i] <= e3[i] * bs[k][i];
				end
				sd_s6[k] <= SDW'(pd_s5[k][0]) + SDW'(pd_s5[k][1]) + SDW'(pd_s5[k][2]);
				tr_s7[k] <= trn[k];
			end
			bs_s5  <= bs;
			deg_s5 <= n3_aux[A3W-1] | n3_zero;
			bs_s6  <= bs_s5;
			deg_s6 <= deg_s5;
			bs_s7  <= bs_s6;
			deg_s7 <= deg_s6;
		end
	end

	// matrix, identity when a vector was degenerate
	elem_t mx [4][4];

	always_comb begin
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				mx[r][c] = (r == c) ? ELEM_ONE : ELEM_ZERO;
			end
		end
		if (!deg_s7) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					mx[r][c] = elem_t'(bs_s7[c][r]);
				end
				mx[3][r] = tr_s7[r];
			end
		end
	end

	// output register: one matrix, sent as four packed rows
	logic       hv_q;
	logic [1:0] row_q;
	elem_t      mx_q [4][4];
	logic       deg_q;
	logic       free;
	logic [1:0] ra;
	logic [1:0] rb;

	assign free     = !hv_q || (!out_stall && row_q == LAST_ROW);
	assign en       = !vld_s7 || free;
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hv_q  <= 1'b0;
			row_q <= '0;
		end else if (free) begin
			hv_q  <= vld_s7;
			row_q <= '0;
		end else if (!out_stall) begin
			row_q <= row_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (free && vld_s7) begin
			mx_q  <= mx;
			deg_q <= deg_s7;
		end
	end

	// rows 0 and 2 carry matrix rows 0,1; rows 1 and 3 carry matrix rows 2,3
	assign ra = {row_q[0], 1'b0};
	assign rb = {row_q[0], 1'b1};

	always_comb begin
		if (row_q[1]) begin
			word_a = {mx_q[ra][0][15:0], mx_q[ra][1][15:0]};
			word_b = {mx_q[ra][2][15:0], mx_q[ra][3][15:0]};
			word_c = {mx_q[rb][0][15:0], mx_q[rb][1][15:0]};
			word_d = {mx_q[rb][2][15:0], mx_q[rb][3][15:0]};
		end else begin
			word_a = {mx_q[ra][0][31:16], mx_q[ra][1][31:16]};
			word_b = {mx_q[ra][2][31:16], mx_q[ra][3][31:16]};
			word_c = {mx_q[rb][0][31:16], mx_q[rb][1][31:16]};
			word_d = {mx_q[rb][2][31:16], mx_q[rb][3][31:16]};
		end
	end

	assign out_valid  = hv_q;
	assign word_row   = row_q;
	assign degenerate = deg_q;
	assign last_row   = (row_q == LAST_ROW);

endmodule

// ===== rtl/core/lkv_chk.sv =====
module lkv_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  word_row,
	input logic [31:0] word_a,
	input logic [31:0] word_b,
	input logic [31:0] word_c,
	input logic [31:0] word_d,
	input logic        degenerate,
	input logic        last_row
);

	// stalled row holds its row number and words a and d
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(word_row) && $stable(word_a)
		&& $stable(word_d))
		else $error("stalled row changed");

	// rows of one matrix follow in order without gaps
	a_next_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last_row |=> out_valid
		&& word_row == $past(word_row) + 2'd1)
		else $error("row sequence broken");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> last_row == (word_row == 2'd3))
		else $error("last_row disagrees with word_row");

	// flag is per matrix
	a_deg_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last_row |=> $stable(degenerate))
		else $error("degenerate changed inside a matrix");

	// degenerate camera gives identity; the check covers row 0
	a_ident: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate && word_row == 2'd0 |-> word_a == 32'h0001_0000
		&& word_b == 32'h0 && word_c == 32'h0000_0001 && word_d == 32'h0)
		else $error("degenerate matrix is not identity");

endmodule

bind look_at_view_matrix_fixed lkv_chk u_lkv_chk (.*);

// ===== sim/look_at_view_matrix_fixed_test.sv =====
`timescale 1ns / 1ps

module look_at_view_matrix_fixed_test;
	import lkv_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam logic signed [31:0] ONE  = 32'sh0001_0000;
	localparam logic signed [31:0] MAXV = 32'sh7fff_ffff;
	localparam logic signed [31:0] MINV = 32'sh8000_0000;
	localparam logic [31:0] IDENT_WORDS [16] = '{32'h0001_0000, 0, 1, 0, 0, 32'h0001_0000, 0, 1,
		0, 0, 0, 0, 0, 0, 0, 0};

	typedef struct {
		logic signed [31:0] v [9];  // eye xyz, target xyz, up xyz
		bit                 ident;  // identity matrix is known up front
	} camera_t;

	typedef struct {
		logic [1:0]  row;
		logic [31:0] w [4];
		logic        deg;
		logic        last;
	} matrix_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] eye_x = 0, eye_y = 0, eye_z = 0;
	logic signed [31:0] target_x = 0, target_y = 0, target_z = 0;
	logic signed [31:0] upward_x = 0, upward_y = 0, upward_z = 0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [1:0] word_row;
	logic [31:0] word_a, word_b, word_c, word_d;
	logic degenerate, last_row;

	matrix_row_t pending_rows [$];
	int error_count = 0;
	int cycle_count = 0;
	int in_idle_pct = 0;
	int out_idle_pct = 0;
	camera_t directed [12];

	look_at_view_matrix_fixed u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.eye_x(eye_x), .eye_y(eye_y), .eye_z(eye_z),
		.target_x(target_x), .target_y(target_y), .target_z(target_z),
		.upward_x(upward_x), .upward_y(upward_y), .upward_z(upward_z),
		.out_valid(out_valid), .out_stall(out_stall),
		.word_row(word_row), .word_a(word_a), .word_b(word_b), .word_c(word_c),
		.word_d(word_d), .degenerate(degenerate), .last_row(last_row)
	);

	always #1 clk = ~clk;

	function automatic longint mag(input longint x);
		return x < 0 ? -x : x;
	endfunction

	function automatic bit normalize(input longint vin [3], output longint vout [3]);
		longint v [3];
		longint m, len;
		longint unsigned sum, rem, res, b;
		v = vin;
		m = mag(v[0]);
		if (mag(v[1]) > m) m = mag(v[1]);
		if (mag(v[2]) > m) m = mag(v[2]);
		if (m == 0) return 0;
		// bring the largest component into [2^29, 2^30)
		for (int k = 0; k < 64; k++) begin
			if (m >= (longint'(1) << 30)) begin
				for (int i = 0; i < 3; i++) v[i] = v[i] / 2;
				m = m / 2;
			end else if (m < (longint'(1) << 29)) begin
				for (int i = 0; i < 3; i++) v[i] = v[i] * 2;
				m = m * 2;
			end
		end
		sum = 0;
		for (int i = 0; i < 3; i++) sum += longint'(v[i] * v[i]);
		rem = sum;
		res = 0;
		b = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (rem >= res + b) begin
				rem -= res + b;
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		len = longint'(res);
		if (len == 0) return 0;
		for (int i = 0; i < 3; i++) vout[i] = (v[i] * 65536) / len;
		return 1;
	endfunction

	function automatic void cross3(input longint a [3], input longint b [3], output longint r [3]);
		r[0] = a[1] * b[2] - a[2] * b[1];
		r[1] = a[2] * b[0] - a[0] * b[2];
		r[2] = a[0] * b[1] - a[1] * b[0];
	endfunction

	function automatic longint translation(input longint e [3], input longint u [3]);
		longint s;
		s = -((e[0] * u[0] + e[1] * u[1] + e[2] * u[2]) / 65536);
		if (s > 64'sd2147483647) s = 64'sd2147483647;
		if (s < -64'sd2147483648) s = -64'sd2147483648;
		return s;
	endfunction

	task automatic push_rows(input logic [31:0] words [16], input logic deg);
		matrix_row_t r;
		for (int k = 0; k < 4; k++) begin
			r.row = 2'(k);
			for (int j = 0; j < 4; j++) r.w[j] = words[k * 4 + j];
			r.deg = deg;
			r.last = (k == LAST_ROW);
			pending_rows.push_back(r);
		end
	endtask

	task automatic predict_view(input camera_t c);
		longint eye [3], dir [3], upv [3], look [3], rgt [3], up2 [3], tmp [3];
		longint mx [4][4];
		logic [31:0] words [16];
		logic [31:0] e1, e2;
		bit deg;
		int w;
		for (int i = 0; i < 3; i++) begin
			eye[i] = longint'(c.v[i]);
			dir[i] = longint'(c.v[3 + i]) - eye[i];
			upv[i] = longint'(c.v[6 + i]);
		end
		deg = 0;
		if (!normalize(dir, look)) begin
			deg = 1;
		end else begin
			for (int i = 0; i < 3; i++) look[i] = -look[i];
			cross3(upv, look, tmp);
			if (!normalize(tmp, rgt)) begin
				deg = 1;
			end else begin
				cross3(look, rgt, tmp);
				if (!normalize(tmp, up2)) deg = 1;
			end
		end
		for (int i = 0; i < 4; i++)
			for (int j = 0; j < 4; j++)
				mx[i][j] = (i == j) ? 65536 : 0;
		if (!deg) begin
			for (int i = 0; i < 3; i++) begin
				mx[i][0] = rgt[i];
				mx[i][1] = up2[i];
				mx[i][2] = look[i];
			end
			mx[3][0] = translation(eye, rgt);
			mx[3][1] = translation(eye, up2);
			mx[3][2] = translation(eye, look);
		end
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 2; j++) begin
				e1 = mx[i][2 * j][31:0];
				e2 = mx[i][2 * j + 1][31:0];
				w = (i / 2) * 4 + j + 2 * (i % 2);
				words[w] = {e1[31:16], e2[31:16]};
				words[w + 8] = {e1[15:0], e2[15:0]};
			end
		end
		push_rows(words, deg);
	endtask

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %h, expected %h", what, got, want);
		error_count++;
	endtask

	// receiver: check accepted rows, then pick next stall
	always @(posedge clk) begin
		matrix_row_t r;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_rows.size() == 0) begin
				report("unexpected row", 32'(word_row), 32'd0);
			end else begin
				r = pending_rows.pop_front();
				if (word_row !== r.row) report("word_row", 32'(word_row), 32'(r.row));
				if (word_a !== r.w[0]) report("word_a", word_a, r.w[0]);
				if (word_b !== r.w[1]) report("word_b", word_b, r.w[1]);
				if (word_c !== r.w[2]) report("word_c", word_c, r.w[2]);
				if (word_d !== r.w[3]) report("word_d", word_d, r.w[3]);
				if (degenerate !== r.deg)
					report("degenerate", 32'(degenerate), 32'(r.deg));
				if (last_row !== r.last) report("last_row", 32'(last_row), 32'(r.last));
			end
		end
		out_stall <= ($urandom_range(99) < out_idle_pct);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("look_at_view_matrix_fixed_test: errors");
			$finish;
		end
	end

	function automatic camera_t cam(input int ex, ey, ez, tx, ty, tz, ux, uy, uz, input bit ident);
		camera_t c;
		c.v = '{ex, ey, ez, tx, ty, tz, ux, uy, uz};
		c.ident = ident;
		return c;
	endfunction

	function automatic logic signed [31:0] scaled_rand();
		return $signed($urandom) >>> $urandom_range(31);
	endfunction

	function automatic camera_t random_camera();
		camera_t c;
		int sel;
		sel = $urandom_range(9);
		c.ident = 0;
		for (int i = 0; i < 9; i++) c.v[i] = $urandom;
		if (sel <= 5) begin
			// well-formed camera: moderate points, up near the y axis
			for (int i = 0; i < 6; i++) c.v[i] = scaled_rand();
			c.v[6] = $signed($urandom) >>> 14;
			c.v[7] = ONE + ($signed($urandom) >>> 15);
			c.v[8] = $signed($urandom) >>> 14;
		end else if (sel == 8) begin
			for (int i = 0; i < 3; i++) c.v[3 + i] = c.v[i];
		end else if (sel == 9) begin
			// up along the view direction
			for (int i = 0; i < 6; i++) c.v[i] = $signed($urandom) >>> 2;
			for (int i = 0; i < 3; i++) c.v[6 + i] = c.v[3 + i] - c.v[i];
		end
		return c;
	endfunction

	task automatic send_camera(input camera_t c);
		in_valid <= 1'b1;
		eye_x <= c.v[0]; eye_y <= c.v[1]; eye_z <= c.v[2];
		target_x <= c.v[3]; target_y <= c.v[4]; target_z <= c.v[5];
		upward_x <= c.v[6]; upward_y <= c.v[7]; upward_z <= c.v[8];
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (c.ident) push_rows(IDENT_WORDS, 1'b1);
		else predict_view(c);
		if ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		while (pending_rows.size() != 0) @(posedge clk);
	endtask

	initial begin
		directed[0]  = cam(0, 0, 0, 0, 0, 0, 0, 0, 0, 1);
		directed[1]  = cam(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, 0, ONE, 0, 1);
		directed[2]  = cam(0, 0, 0, 0, 0, -ONE, 0, ONE, 0, 0);
		directed[3]  = cam(0, 0, 0, 0, ONE, 0, 0, ONE, 0, 1);
		directed[4]  = cam(0, 0, 0, ONE, 0, 0, 0, 0, 0, 1);
		directed[5]  = cam(MINV, MINV, MINV, MAXV, MAXV, MAXV, MAXV, MINV, 0, 0);
		directed[6]  = cam(MAXV, MAXV, MAXV, MINV, MINV, MINV, MINV, MINV, MAXV, 0);
		directed[7]  = cam(MAXV, MINV, MAXV, MINV, MAXV, MINV, ONE, 0, 0, 0);
		directed[8]  = cam(0, 0, 0, 1, 0, 0, 0, 0, 1, 0);
		directed[9]  = cam(3 * ONE, 2 * ONE, 5 * ONE, 0, 0, 0, 0, ONE, 0, 0);
		directed[10] = cam(-1, -1, -1, 1, 1, 1, 0, 0, -1, 0);
		directed[11] = cam(1, 1, 1, 1, 1, 1, MINV, MAXV, 7, 1);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) send_camera(directed[i]);
		// hold off until the directed matrices are all out
		in_valid <= 1'b0;
		@(posedge clk);
		wait_drained();

		in_idle_pct = 35;
		out_idle_pct = 77;
		repeat (90) send_camera(random_camera());
		in_idle_pct = 77;
		out_idle_pct = 35;
		repeat (90) send_camera(random_camera());
		in_idle_pct = 0;
		out_idle_pct = 0;
		repeat (80) send_camera(random_camera());
		in_valid <= 1'b0;

		wait_drained();
		repeat (120) @(posedge clk);
		if (error_count == 0)
			$display("look_at_view_matrix_fixed_test: clean");
		else
			$display("look_at_view_matrix_fixed_test: errors");
		$finish;
	end

endmodule

// ===== look_at_view_matrix_fixed.f =====
rtl/core/lkv_pkg.sv
rtl/core/lkv_norm.sv
rtl/core/look_at_view_matrix_fixed.sv
rtl/core/lkv_chk.sv
sim/look_at_view_matrix_fixed_test.sv
